@@ rtl/ito_pkg.sv @@
package ito_pkg;

  localparam int TIME_W  = 64;
  localparam int VAL_W   = 32;
  localparam int NVAL    = 9;
  localparam int ROW_W   = NVAL * VAL_W;
  localparam int WB      = 24;
  localparam int HEAD_W  = 40;
  localparam int ACC_W   = HEAD_W + WB + 2;
  localparam int YAW_IDX = 8;
  localparam int KW      = 4;

  localparam logic [KW-1:0] CORR_K = KW'(NVAL);

  localparam logic FUNC_PUSH  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [TIME_W-1:0] stamp_t;

endpackage

@@ rtl/ito_store.sv @@
module ito_store #(
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  ito_pkg::stamp_t    wtime_i,
  input  ito_pkg::row_t      wrow_i,
  input  logic [AW-1:0]      traddr_i,
  output ito_pkg::stamp_t    rtime_o,
  input  logic [AW-1:0]      vraddr_i,
  output ito_pkg::row_t      rrow_o
);
  import ito_pkg::*;

  stamp_t time_mem [DEPTH];
  row_t   row_mem  [DEPTH];
  stamp_t rtime_q;
  row_t   rrow_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      time_mem[waddr_i] <= wtime_i;
      row_mem[waddr_i]  <= wrow_i;
    end
    rtime_q <= time_mem[traddr_i];
    rrow_q  <= row_mem[vraddr_i];
  end

  assign rtime_o = rtime_q;
  assign rrow_o  = rrow_q;

endmodule

@@ rtl/ito_div.sv @@
module ito_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [31:0]           num_i,
  input  logic [31:0]           den_i,
  output logic                  done_o,
  output logic [ito_pkg::WB:0]  quo_o
);
  import ito_pkg::*;

  logic [32+WB:0] n_full;
  logic [31:0]    rem_q;
  logic [WB:0]    sh_q;
  logic [31:0]    den_q;
  logic [4:0]     cnt_q;
  logic           busy_q;
  logic           done_q;
  logic [32:0]    r2;
  logic [32:0]    diff;
  logic           ge;

  assign n_full = {1'b0, num_i, {WB{1'b0}}} + {{(WB+2){1'b0}}, den_i[31:1]};
  assign r2     = {rem_q, sh_q[WB]};
  assign diff   = r2 - {1'b0, den_q};
  assign ge     = r2 >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 5'd1);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(WB + 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= n_full[32+WB:WB+1];
      sh_q  <= n_full[WB:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[31:0] : r2[31:0];
      sh_q  <= {sh_q[WB-1:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = sh_q;

endmodule

@@ rtl/ito_mac.sv @@
module ito_mac (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [ito_pkg::WB:0]             w1_i,
  input  logic signed [ito_pkg::HEAD_W-1:0] lo_i,
  input  logic signed [ito_pkg::HEAD_W-1:0] hi_i,
  output logic                             done_o,
  output logic signed [ito_pkg::HEAD_W-1:0] res_o
);
  import ito_pkg::*;

  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (WB - 1);
  localparam logic [WB:0] ONE_W = (WB+1)'(1) << WB;

  logic [WB:0]                w1_q;
  logic signed [HEAD_W-1:0]   lo_q;
  logic signed [HEAD_W-1:0]   hi_q;
  logic signed [ACC_W-1:0]    ph_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic [WB:0]                w2;
  logic [1:0]                 ph_cnt_q;
  logic                       done_q;

  assign w2 = ONE_W - w1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_cnt_q <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= ph_cnt_q == 2'd2;
      if (start_i) ph_cnt_q <= 2'd1;
      else if (ph_cnt_q == 2'd1) ph_cnt_q <= 2'd2;
      else ph_cnt_q <= 2'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      w1_q <= w1_i;
      lo_q <= lo_i;
      hi_q <= hi_i;
    end
    if (ph_cnt_q == 2'd1) ph_q <= ACC_W'($signed({1'b0, w1_q}) * hi_q);
    if (ph_cnt_q == 2'd2) acc_q <= ph_q + ACC_W'($signed({1'b0, w2}) * lo_q) + RND;
  end

  assign done_o = done_q;
  assign res_o  = HEAD_W'(acc_q >>> WB);

endmodule

@@ rtl/imu_timestamp_interpolator.sv @@
// IMU sample store with timestamp interpolation.
// Input stream: s_axis_tuser selects push (0) or query (1); s_axis_tdata carries the
// timestamp and nine Q values. A push stores the newest sample (dropping the oldest
// once DEPTH are held) and yields no result. A query yields one result on the master
// stream: m_axis_tuser is the found flag, m_axis_tdata the nine values.
// Values are interpolated when samples lie on both sides of the stamp; with one side
// only, that sample's values are copied, and with none they are zero. A query scans
// the time memory one entry per cycle, fetches both rows, shifts the time span until
// it is under 2^32, runs the bit-serial divider and passes each value through the
// shared multiplier (9 or 10 values, the tenth being the heading wrap correction).
// One request is in work at a time; s_axis_tready is low meanwhile.
// Reset empties the store; memory contents are not cleared, entries are only read
// once written. The result sits in an output register; while the receiver stalls,
// further pushes are still taken, and a next query waits at its end for the register.
module imu_timestamp_interpolator #(
  parameter int DEPTH     = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // stamp, acc_x_in, acc_y_in, acc_z_in, rate_x_in, rate_y_in, rate_z_in,
  // roll_in, pitch_in, heading_in
  input  logic [351:0] s_axis_tdata,
  // func
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // acc_x_out, acc_y_out, acc_z_out, rate_x_out, rate_y_out, rate_z_out,
  // roll_out, pitch_out, heading_out
  output logic [287:0] m_axis_tdata,
  // found
  output logic         m_axis_tuser
);
  import ito_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
  localparam logic signed [HEAD_W-1:0] Q10  = HEAD_W'(10)  <<< FRAC_BITS;
  localparam logic signed [HEAD_W-1:0] Q170 = HEAD_W'(170) <<< FRAC_BITS;
  localparam logic signed [HEAD_W-1:0] Q180 = HEAD_W'(180) <<< FRAC_BITS;
  localparam logic signed [HEAD_W-1:0] Q360 = HEAD_W'(360) <<< FRAC_BITS;
  localparam logic signed [HEAD_W-1:0] SMAX = HEAD_W'(32'sh7FFF_FFFF);
  localparam logic signed [HEAD_W-1:0] SMIN = -SMAX - HEAD_W'(1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_SCAN  = 11'b000_0000_0010,
    S_VRD   = 11'b000_0000_0100,
    S_VRDH  = 11'b000_0000_1000,
    S_VLAT  = 11'b000_0001_0000,
    S_NORM  = 11'b000_0010_0000,
    S_DIVW  = 11'b000_0100_0000,
    S_MACGO = 11'b000_1000_0000,
    S_MACW  = 11'b001_0000_0000,
    S_FIX   = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [AW-1:0] newest_q, ptr_q, rd_slot_q, ls_q, hs_q, wslot;
  logic [CW-1:0] fill_q, left_q;
  logic          rd_vld_q, fl_q, fh_q;
  stamp_t        ts_q, tl_q, th_q, n1_q, d_q;
  row_t          lo_row_q, hi_row_q, rrow;
  stamp_t        rtime;
  logic [8:0][31:0] res_q;
  logic [KW-1:0] k_q;
  logic [WB:0]   w1_q, quo;
  logic          div_done, mac_done, mac_start, div_start;
  logic signed [HEAD_W-1:0] mac_lo, mac_hi, mac_res, corr_q;
  logic signed [HEAD_W-1:0] hl, hh, abs_l, abs_h, ca, cb, y;
  logic          c1, c2, c3, c4, corr_any;
  logic [31:0]   lo_v, hi_v;
  logic [3:0]    vidx;
  logic          s_acc, push, out_ok;

  assign s_axis_tready = state_q == S_IDLE;
  assign s_acc  = s_axis_tvalid && s_axis_tready;
  assign push   = s_acc && (s_axis_tuser == FUNC_PUSH);
  assign wslot  = (newest_q == LAST_SLOT) ? '0 : newest_q + AW'(1);
  assign out_ok = !m_axis_tvalid || m_axis_tready;

  ito_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk_i    (clk_i),
    .we_i     (push),
    .waddr_i  (wslot),
    .wtime_i  (s_axis_tdata[63:0]),
    .wrow_i   (s_axis_tdata[351:64]),
    .traddr_i (ptr_q),
    .rtime_o  (rtime),
    .vraddr_i ((state_q == S_VRD) ? ls_q : hs_q),
    .rrow_o   (rrow)
  );

  assign div_start = (state_q == S_NORM) && (d_q[63:32] == '0);

  ito_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (n1_q[31:0]),
    .den_i   (d_q[31:0]),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign hl    = HEAD_W'($signed(lo_row_q[YAW_IDX*VAL_W +: VAL_W]));
  assign hh    = HEAD_W'($signed(hi_row_q[YAW_IDX*VAL_W +: VAL_W]));
  assign abs_l = hl[HEAD_W-1] ? -hl : hl;
  assign abs_h = hh[HEAD_W-1] ? -hh : hh;
  assign c1 = (hl < -Q170) && (hh > Q170);
  assign c2 = (hl > Q170) && (hh < -Q170);
  assign c3 = (hl < 0) && (hl > -Q10) && (hh > 0) && (hh < Q10);
  assign c4 = (hl < Q10) && (hl > 0) && (hh < 0) && (hh > -Q10);
  assign corr_any = c1 || c2 || c3 || c4;

  always_comb begin
    ca = Q180 - abs_l;
    cb = Q180 - abs_h;
    if (c3) begin
      ca = -hl;
      cb = hh;
    end else if (c4) begin
      ca = hl;
      cb = -hh;
    end
  end

  assign vidx   = (k_q == CORR_K) ? 4'd0 : k_q;
  assign lo_v   = lo_row_q[vidx*VAL_W +: VAL_W];
  assign hi_v   = hi_row_q[vidx*VAL_W +: VAL_W];
  assign mac_lo = (k_q == CORR_K) ? ca : HEAD_W'($signed(lo_v));
  assign mac_hi = (k_q == CORR_K) ? cb : HEAD_W'($signed(hi_v));
  assign mac_start = state_q == S_MACGO;

  ito_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_start),
    .w1_i    (w1_q),
    .lo_i    (mac_lo),
    .hi_i    (mac_hi),
    .done_o  (mac_done),
    .res_o   (mac_res)
  );

  always_comb begin
    y = hl + corr_q;
    if (c1) begin
      y = hl - corr_q;
      if (y < -Q180) y = y + Q360;
    end else if (c2) begin
      if (y > Q180) y = y - Q360;
    end else if (c4) begin
      y = hl - corr_q;
    end
    if (y > SMAX) y = SMAX;
    if (y < SMIN) y = SMIN;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_acc && (s_axis_tuser == FUNC_QUERY)) begin
          state_d = (fill_q == '0) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN:  if (left_q == '0 && !rd_vld_q) state_d = S_VRD;
      S_VRD:   state_d = (fl_q || fh_q) ? S_VRDH : S_DONE;
      S_VRDH:  state_d = S_VLAT;
      S_VLAT:  state_d = (fl_q && fh_q) ? S_NORM : S_DONE;
      S_NORM:  if (div_start) state_d = S_DIVW;
      S_DIVW:  if (div_done) state_d = S_MACGO;
      S_MACGO: state_d = S_MACW;
      S_MACW: begin
        if (mac_done) begin
          if (k_q == CORR_K) state_d = S_FIX;
          else if (k_q == KW'(NVAL - 1)) state_d = corr_any ? S_MACGO : S_DONE;
          else state_d = S_MACGO;
        end
      end
      S_FIX:   state_d = S_DONE;
      S_DONE:  if (out_ok) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      newest_q      <= '0;
      fill_q        <= '0;
      left_q        <= '0;
      rd_vld_q      <= 1'b0;
      fl_q          <= 1'b0;
      fh_q          <= 1'b0;
      k_q           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (push) begin
        newest_q <= wslot;
        if (fill_q != FULL_CNT) fill_q <= fill_q + CW'(1);
      end
      if (state_q == S_IDLE) begin
        left_q   <= fill_q;
        rd_vld_q <= 1'b0;
        fl_q     <= 1'b0;
        fh_q     <= 1'b0;
        k_q      <= '0;
      end
      if (state_q == S_SCAN) begin
        rd_vld_q <= left_q != '0;
        if (left_q != '0) left_q <= left_q - CW'(1);
        if (rd_vld_q) begin
          if (rtime < ts_q) fl_q <= 1'b1;
          else fh_q <= 1'b1;
        end
      end
      if (state_q == S_MACW && mac_done) k_q <= k_q + KW'(1);
      if (state_q == S_DONE && out_ok) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      ts_q  <= s_axis_tdata[63:0];
      ptr_q <= newest_q;
      res_q <= '0;
    end
    if (state_q == S_SCAN) begin
      rd_slot_q <= ptr_q;
      if (left_q != '0) ptr_q <= (ptr_q == '0) ? LAST_SLOT : ptr_q - AW'(1);
      if (rd_vld_q) begin
        if (rtime < ts_q) begin
          if (!fl_q) begin
            ls_q <= rd_slot_q;
            tl_q <= rtime;
          end
        end else begin
          hs_q <= rd_slot_q;
          th_q <= rtime;
        end
      end
    end
    if (state_q == S_VRDH) lo_row_q <= rrow;
    if (state_q == S_VLAT) begin
      hi_row_q <= rrow;
      n1_q     <= ts_q - tl_q;
      d_q      <= th_q - tl_q;
      if (fl_q && !fh_q) res_q <= lo_row_q;
      if (fh_q && !fl_q) res_q <= rrow;
    end
    if (state_q == S_NORM && !div_start) begin
      n1_q <= n1_q >> 1;
      d_q  <= d_q >> 1;
    end
    if (state_q == S_DIVW && div_done) w1_q <= quo;
    if (state_q == S_MACW && mac_done) begin
      if (k_q == CORR_K) corr_q <= mac_res;
      else res_q[vidx] <= mac_res[31:0];
    end
    if (state_q == S_FIX) res_q[YAW_IDX] <= y[31:0];
    if (state_q == S_DONE && out_ok) begin
      m_axis_tdata <= res_q;
      m_axis_tuser <= fl_q || fh_q;
    end
  end

endmodule

@@ tb/imu_interp_checker.sv @@
module imu_interp_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [351:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [287:0] m_axis_tdata,
  input  logic         m_axis_tuser,
  output int           fail_cnt_o,
  output int           pending_o,
  output int           results_o,
  output int           found_cnt_o
);
  import ito_pkg::*;

  localparam int SLOTS = 32;

  typedef struct {
    logic            found;
    logic [31:0]     val[NVAL];
  } imu_result_t;

  longint unsigned hist_time[SLOTS];
  logic [31:0]     hist_val[SLOTS][NVAL];
  int              newest;
  int              fill;
  imu_result_t     want_q[$];

  function automatic longint qf(longint units);
    return units * 65536;
  endfunction

  function automatic longint blend(longint lo, longint hi, longint w1);
    longint w2;
    longint acc;
    w2  = (64'sd1 << WB) - w1;
    acc = w1 * hi + w2 * lo + (64'sd1 << (WB - 1));
    return acc >>> WB;
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic imu_result_t interp_at(longint unsigned ts);
    imu_result_t     r;
    int              hs, ls, s;
    bit              fh, fl;
    longint unsigned n1, d;
    longint          w1, lv, hv, a, b, y;
    fh = 0; fl = 0; hs = 0; ls = 0;
    r.found = 0;
    for (int k = 0; k < NVAL; k++) r.val[k] = '0;
    for (int age = fill - 1; age >= 0; age--) begin
      s = (newest + SLOTS - age) % SLOTS;
      if (hist_time[s] >= ts) begin
        hs = s; fh = 1; break;
      end
    end
    for (int age = 0; age < fill; age++) begin
      s = (newest + SLOTS - age) % SLOTS;
      if (hist_time[s] < ts) begin
        ls = s; fl = 1; break;
      end
    end
    r.found = fh | fl;
    if (fh && fl) begin
      n1 = ts - hist_time[ls];
      d  = hist_time[hs] - hist_time[ls];
      while (d >= 64'h1_0000_0000) begin
        d  = d >> 1;
        n1 = n1 >> 1;
      end
      w1 = longint'(((n1 << WB) + d / 2) / d);
      for (int k = 0; k < NVAL; k++)
        r.val[k] = clip32(blend(longint'(signed'(hist_val[ls][k])),
                                longint'(signed'(hist_val[hs][k])), w1));
      lv = longint'(signed'(hist_val[ls][YAW_IDX]));
      hv = longint'(signed'(hist_val[hs][YAW_IDX]));
      y  = 0;
      a  = qf(180) - (lv < 0 ? -lv : lv);
      b  = qf(180) - (hv < 0 ? -hv : hv);
      if (lv < qf(-170) && hv > qf(170)) begin
        y = lv - blend(a, b, w1);
        if (y < qf(-180)) y += qf(360);
        r.val[YAW_IDX] = clip32(y);
      end
      if (lv > qf(170) && hv < qf(-170)) begin
        y = lv + blend(a, b, w1);
        if (y > qf(180)) y -= qf(360);
        r.val[YAW_IDX] = clip32(y);
      end
      if (lv < 0 && lv > qf(-10) && hv > 0 && hv < qf(10))
        r.val[YAW_IDX] = clip32(lv + blend(-lv, hv, w1));
      if (lv < qf(10) && lv > 0 && hv < 0 && hv > qf(-10))
        r.val[YAW_IDX] = clip32(lv - blend(lv, -hv, w1));
    end else if (fl) begin
      for (int k = 0; k < NVAL; k++) r.val[k] = hist_val[ls][k];
    end else if (fh) begin
      for (int k = 0; k < NVAL; k++) r.val[k] = hist_val[hs][k];
    end
    return r;
  endfunction

  task automatic flag_miss(string what, logic [31:0] exp_v, logic [31:0] got_v);
    if (fail_cnt_o < 10)
      $display("mismatch result %0d %s: expected %h got %h", results_o, what, exp_v, got_v);
    fail_cnt_o++;
  endtask

  assign pending_o = want_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    imu_result_t w;
    if (!rst_ni) begin
      newest <= 0;
      fill   <= 0;
      want_q.delete();
      fail_cnt_o  = 0;
      results_o   = 0;
      found_cnt_o = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == FUNC_PUSH) begin
          hist_time[(newest + 1) % SLOTS] = s_axis_tdata[63:0];
          for (int k = 0; k < NVAL; k++)
            hist_val[(newest + 1) % SLOTS][k] = s_axis_tdata[64 + 32*k +: 32];
          newest <= (newest + 1) % SLOTS;
          if (fill < SLOTS) fill <= fill + 1;
        end else begin
          want_q.push_back(interp_at(s_axis_tdata[63:0]));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (want_q.size() == 0) begin
          if (fail_cnt_o < 10) $display("result %0d arrived with none expected", results_o);
          fail_cnt_o++;
        end else begin
          w = want_q.pop_front();
          if (w.found !== m_axis_tuser) flag_miss("found", 32'(w.found), 32'(m_axis_tuser));
          for (int k = 0; k < NVAL; k++)
            if (w.val[k] !== m_axis_tdata[32*k +: 32])
              flag_miss($sformatf("value %0d", k), w.val[k], m_axis_tdata[32*k +: 32]);
          if (w.found) found_cnt_o++;
        end
        results_o++;
      end
    end
  end

endmodule

@@ tb/tb_imu_timestamp_interpolator.sv @@
module tb_imu_timestamp_interpolator;
  import ito_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [351:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [287:0] m_axis_tdata;
  logic         m_axis_tuser;

  int fail_cnt, pending, results, found_cnt;
  int pushes, queries;
  longint cycles;
  longint unsigned now_t;

  always #5 clk_i = ~clk_i;

  imu_timestamp_interpolator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  imu_interp_checker u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending),
    .results_o     (results),
    .found_cnt_o   (found_cnt)
  );

  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] deg(int whole, int frac);
    return 32'(whole * 65536 + frac);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(0, 200000)) - 32'd100000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_heading();
    case ($urandom_range(0, 5))
      0: return deg($urandom_range(170, 179), $urandom_range(0, 65535));
      1: return -deg($urandom_range(170, 179), $urandom_range(0, 65535));
      2: return deg($urandom_range(0, 9), $urandom_range(0, 65535));
      3: return -deg($urandom_range(0, 9), $urandom_range(0, 65535));
      4: return $urandom;
      default: return deg($urandom_range(0, 360), 0) - deg(180, 0);
    endcase
  endfunction

  task automatic send(logic func, longint unsigned stamp, logic [31:0] hd, bit flat);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tuser        <= func;
    s_axis_tdata[63:0]  <= stamp;
    for (int k = 0; k < NVAL; k++)
      s_axis_tdata[64 + 32*k +: 32] <= (k == YAW_IDX) ? hd : (flat ? hd : pick_value());
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (func == FUNC_PUSH) pushes++;
    else queries++;
  endtask

  always @(posedge clk_i) begin
    int mode_left;
    int stall;
    if (mode_left == 0) mode_left = $urandom_range(100, 600);
    mode_left--;
    if (stall > 0) begin
      stall--;
      m_axis_tready <= 1'b0;
    end else if (mode_left > 300) begin
      m_axis_tready <= 1'b1;
    end else begin
      stall = idle_len();
      m_axis_tready <= (stall == 0);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 3_000_000) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_imu_timestamp_interpolator: errors");
      $finish;
    end
  end

  initial begin
    longint unsigned t;
    int p;
    pushes = 0;
    queries = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(FUNC_QUERY, 64'd1500, '0, 0);
    send(FUNC_PUSH, 64'd1000, -deg(175, 0), 0);
    send(FUNC_PUSH, 64'd2000, deg(175, 0), 0);
    send(FUNC_QUERY, 64'd1500, '0, 0);
    send(FUNC_QUERY, 64'd500, '0, 0);
    send(FUNC_QUERY, 64'd3000, '0, 0);
    send(FUNC_QUERY, 64'd2000, '0, 0);
    send(FUNC_PUSH, 64'd3000, -deg(5, 0), 0);
    send(FUNC_PUSH, 64'd4000, deg(5, 0), 0);
    send(FUNC_QUERY, 64'd3500, '0, 0);
    send(FUNC_PUSH, 64'd5000, -deg(3, 0), 0);
    send(FUNC_QUERY, 64'd4500, '0, 0);
    send(FUNC_PUSH, 64'd6000, deg(175, 0), 0);
    send(FUNC_PUSH, 64'd7000, -deg(175, 0), 0);
    send(FUNC_QUERY, 64'd6600, '0, 0);
    send(FUNC_PUSH, 64'd7000 + (64'd1 << 40), 32'h7fff_ffff, 1);
    send(FUNC_QUERY, 64'd7000 + (64'd1 << 39), '0, 0);
    send(FUNC_PUSH, 64'hffff_ffff_ffff_ffff, 32'h8000_0000, 1);
    send(FUNC_QUERY, 64'hffff_ffff_ffff_fffe, '0, 0);
    send(FUNC_QUERY, 64'hffff_ffff_ffff_ffff, '0, 0);
    send(FUNC_PUSH, 64'd0, 32'h8000_0000, 1);
    send(FUNC_QUERY, 64'd0, '0, 0);
    send(FUNC_QUERY, 64'd1, '0, 0);

    now_t = 64'd10000;
    for (int n = 0; n < 930; n++) begin
      p = $urandom_range(0, 99);
      if (p < 50) begin
        if ($urandom_range(0, 19) == 0) now_t += 64'd1 << $urandom_range(32, 40);
        else now_t += $urandom_range(1, 5000);
        send(FUNC_PUSH, now_t, pick_heading(), 0);
      end else if (p < 88) begin
        t = now_t - $urandom_range(0, 60000);
        if ($urandom_range(0, 9) == 0) t = now_t + $urandom_range(0, 1000);
        send(FUNC_QUERY, t, '0, 0);
      end else if (p < 94) begin
        send(FUNC_PUSH, {$urandom, $urandom}, pick_heading(), 0);
      end else begin
        send(FUNC_QUERY, {$urandom, $urandom}, $urandom, 0);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("requests: %0d pushes, %0d queries; %0d results checked, %0d with a sample found",
             pushes, queries, results, found_cnt);
    if (fail_cnt == 0) begin
      $display("tb_imu_timestamp_interpolator: clean");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("tb_imu_timestamp_interpolator: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ito_pkg.sv
rtl/ito_store.sv
rtl/ito_div.sv
rtl/ito_mac.sv
rtl/imu_timestamp_interpolator.sv
tb/imu_interp_checker.sv
tb/tb_imu_timestamp_interpolator.sv
